@@ src/s256_pkg.sv @@
// shared types and constants for the sha-256 byte stream hasher
package s256_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int BLOCK_WORDS = 16;
  localparam int ROUNDS      = 64;
  localparam int HASH_WORDS  = 8;
  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  // byte position where the 64-bit length field starts
  localparam logic [5:0] LEN_START = 6'd56;

  typedef enum logic {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    PAD_NONE     = 2'd0,
    PAD_MARK     = 2'd1,   // 0x80 then zeros to block end
    PAD_MARK_LEN = 2'd2,   // 0x80, zeros, length
    PAD_LEN      = 2'd3    // zeros, length
  } pad_t;

  typedef struct packed {
    logic       absorb;
    pad_t       pad;
    logic       start;
    logic       round;
    logic [5:0] round_idx;
    logic       fold;
    logic       next_word;
    logic       clear;
  } s256_cmd_t;

  typedef struct packed {
    logic fill_high;   // no room left for the length field
    logic fill_last;   // next byte completes the block
    logic word_last;   // digest word 7 is on the output
  } s256_stat_t;

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

@@ src/s256_if.sv @@
// valid/ready channel interfaces for message bytes and digest words
interface s256_msg_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source(output valid, command, data_byte, input ready);
  modport sink(input valid, command, data_byte, output ready);
endinterface

interface s256_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ src/s256_ctrl.sv @@
// sequencer: byte intake, round counting, padding order and digest output
module s256_ctrl
  import s256_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       msg_valid,
  input  logic       msg_command,
  output logic       msg_ready,
  output logic       dig_valid,
  input  logic       dig_ready,
  input  s256_stat_t stat,
  output s256_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RUN  = 5'b00010,
    ST_FOLD = 5'b00100,
    ST_PAD2 = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [5:0] round, round_next;
  logic       finishing, finishing_next;
  logic       second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round     <= '0;
      finishing <= 1'b0;
      second    <= 1'b0;
    end else begin
      state     <= state_next;
      round     <= round_next;
      finishing <= finishing_next;
      second    <= second_next;
    end
  end

  always_comb begin
    state_next     = state;
    round_next     = round;
    finishing_next = finishing;
    second_next    = second;
    cmd            = '0;
    cmd.pad        = PAD_NONE;
    cmd.round_idx  = round;
    msg_ready      = 1'b0;
    dig_valid      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        msg_ready = 1'b1;
        if (msg_valid) begin
          if (msg_command == CMD_FINISH) begin
            cmd.pad        = stat.fill_high ? PAD_MARK : PAD_MARK_LEN;
            second_next    = stat.fill_high;
            finishing_next = 1'b1;
            cmd.start      = 1'b1;
            round_next     = '0;
            state_next     = ST_RUN;
          end else begin
            cmd.absorb = 1'b1;
            if (stat.fill_last) begin
              cmd.start  = 1'b1;
              round_next = '0;
              state_next = ST_RUN;
            end
          end
        end
      end
      ST_RUN: begin
        cmd.round  = 1'b1;
        round_next = round + 6'd1;
        if (round == 6'(ROUNDS - 1)) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (second) begin
          state_next = ST_PAD2;
        end else if (finishing) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PAD2: begin
        cmd.pad     = PAD_LEN;
        cmd.start   = 1'b1;
        second_next = 1'b0;
        round_next  = '0;
        state_next  = ST_RUN;
      end
      ST_OUT: begin
        dig_valid = 1'b1;
        if (dig_ready) begin
          cmd.next_word = 1'b1;
          if (stat.word_last) begin
            cmd.clear      = 1'b1;
            finishing_next = 1'b0;
            state_next     = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/s256_dp.sv @@
// datapath: block window, round logic, chaining value, counters
module s256_dp
  import s256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  s256_cmd_t   cmd,
  input  logic [7:0]  data_byte,
  output s256_stat_t  stat,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0] w      [BLOCK_WORDS];
  logic [31:0] w_next [BLOCK_WORDS];
  logic [31:0] v      [HASH_WORDS];
  logic [31:0] h      [HASH_WORDS];
  logic [5:0]  fill;
  logic [63:0] bit_count;
  logic [2:0]  word_idx;

  logic [31:0] big0, big1, choose, major, t1, t2, sig0, sig1, w_new;

  always_comb begin
    big1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1     = v[7] + big1 + choose + ROUND_K[cmd.round_idx] + w[0];
    big0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2     = big0 + major;
    sig0   = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    sig1   = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new  = sig1 + w[9] + sig0 + w[0];
  end

  // byte writes, padding and schedule shift into the block window
  always_comb begin
    logic [5:0] jb;
    logic [7:0] len_byte;
    int         sh;
    for (int wi = 0; wi < BLOCK_WORDS; wi++) begin
      w_next[wi] = w[wi];
    end
    if (cmd.absorb) begin
      w_next[fill[5:2]][8 * (3 - fill[1:0]) +: 8] = data_byte;
    end
    for (int wi = 0; wi < BLOCK_WORDS; wi++) begin
      for (int bi = 0; bi < 4; bi++) begin
        jb       = 6'(wi * 4 + bi);
        sh       = 8 * (7 - (bi + 4 * (wi & 1)));
        len_byte = bit_count[sh +: 8];
        case (cmd.pad)
          PAD_MARK: begin
            if (jb == fill) begin
              w_next[wi][8 * (3 - bi) +: 8] = PAD_MARK_BYTE;
            end else if (jb > fill) begin
              w_next[wi][8 * (3 - bi) +: 8] = 8'h00;
            end
          end
          PAD_MARK_LEN: begin
            if (jb >= LEN_START) begin
              w_next[wi][8 * (3 - bi) +: 8] = len_byte;
            end else if (jb == fill) begin
              w_next[wi][8 * (3 - bi) +: 8] = PAD_MARK_BYTE;
            end else if (jb > fill) begin
              w_next[wi][8 * (3 - bi) +: 8] = 8'h00;
            end
          end
          PAD_LEN: begin
            w_next[wi][8 * (3 - bi) +: 8] = (jb >= LEN_START) ? len_byte : 8'h00;
          end
          default: begin
          end
        endcase
      end
    end
    if (cmd.round) begin
      for (int wi = 0; wi < BLOCK_WORDS - 1; wi++) begin
        w_next[wi] = w[wi + 1];
      end
      w_next[BLOCK_WORDS - 1] = w_new;
    end
  end

  always_ff @(posedge clk) begin
    for (int wi = 0; wi < BLOCK_WORDS; wi++) begin
      w[wi] <= w_next[wi];
    end
    if (cmd.start) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        v[i] <= h[i];
      end
    end else if (cmd.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        h[i] <= INIT_HASH[i];
      end
      fill      <= '0;
      bit_count <= '0;
      word_idx  <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < HASH_WORDS; i++) begin
          h[i] <= h[i] + v[i];
        end
      end
      if (cmd.absorb) begin
        fill      <= fill + 6'd1;
        bit_count <= bit_count + 64'd8;
      end
      if (cmd.next_word) begin
        word_idx <= word_idx + 3'd1;
      end
    end
  end

  assign stat.fill_high = (fill >= LEN_START);
  assign stat.fill_last = (fill == 6'(BLOCK_BYTES - 1));
  assign stat.word_last = (word_idx == 3'(HASH_WORDS - 1));

  assign digest_word = h[word_idx];
  assign word_index  = word_idx;
  assign last_word   = stat.word_last;

endmodule

@@ src/sha256_byte_stream_hasher.sv @@
// sha-256 hasher top level: byte input channel, digest word output channel
//
// channel   role    payload                               transfer when
// msg       sink    command, data_byte                    msg.valid && msg.ready
// digest    source  digest_word, word_index, last_word    digest.valid && digest.ready
//
// data bytes are taken while msg.ready is high; the byte that fills the 64-byte block
// starts the round sequence and then a fold before the next byte is taken
// finish runs the padded block, or two blocks when fewer than nine bytes of room remain,
// then eight digest words at one per cycle while digest.ready is high
// a single round unit computes one sha-256 round per cycle; msg.ready is low from
// compression start until the fold, or on finish until the last digest transfer
// reset (rst, synchronous) loads the initial hash values and clears counts
module sha256_byte_stream_hasher
  import s256_pkg::*;
(
  input logic       clk,
  input logic       rst,
  s256_msg_if.sink  msg,
  s256_dig_if.source digest
);

  s256_cmd_t  cmd;
  s256_stat_t stat;
  logic       msg_ready;
  logic       dig_valid;

  // sequencer drives the handshakes and the datapath commands
  s256_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .msg_valid   (msg.valid),
    .msg_command (msg.command),
    .msg_ready   (msg_ready),
    .dig_valid   (dig_valid),
    .dig_ready   (digest.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // datapath holds the block window, working variables and chaining value
  s256_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (msg.data_byte),
    .stat        (stat),
    .digest_word (digest.digest_word),
    .word_index  (digest.word_index),
    .last_word   (digest.last_word)
  );

  assign msg.ready    = msg_ready;
  assign digest.valid = dig_valid;

endmodule

@@ src/s256_chk.sv @@
// port-level checks for the sha-256 hasher, bound to the top level
module s256_chk (
  input logic        clk,
  input logic        rst,
  input logic        msg_ready,
  input logic        dig_valid,
  input logic        dig_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // stalled digest word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_ready |=> dig_valid && $stable(digest_word) && $stable(word_index))
    else $error("digest word changed under stall");

  // no message intake while a digest is being emitted
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg_ready && dig_valid))
    else $error("message ready during digest output");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  a_word_seq: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_ready && !last_word |=>
      dig_valid && (word_index == 3'($past(word_index) + 3'd1)))
    else $error("digest words out of sequence");

  a_end_digest: assert property (@(posedge clk) disable iff (rst)
    dig_valid && dig_ready && last_word |=> !dig_valid && msg_ready)
    else $error("block not idle after last digest word");

endmodule

bind sha256_byte_stream_hasher s256_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .msg_ready   (msg.ready),
  .dig_valid   (digest.valid),
  .dig_ready   (digest.ready),
  .digest_word (digest.digest_word),
  .word_index  (digest.word_index),
  .last_word   (digest.last_word)
);
